[rtl/ctb_pkg.sv]
// Shared types and constants for the countdown timer bank.
`default_nettype none
package ctb_pkg;

  localparam int NUM_TIMERS_DEF = 8;
  localparam int QUEUE_DEPTH    = 2;

  localparam int CMD_W  = 2;
  localparam int ID_W   = 8;
  localparam int PAY_W  = 8;
  localparam int TIME_W = 31;
  localparam int REM_W  = 32;
  localparam int NODE_W = 8;

  localparam logic [CMD_W-1:0] CMD_SET    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  localparam logic [REM_W-1:0] REM_MAX = 32'h7FFF_FFFF;
  localparam logic [REM_W-1:0] REM_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_SET    = 2'b00,
    OP_CANCEL = 2'b01,
    OP_TICK   = 2'b10
  } op_t;

  // value: delay for a set, signed elapsed time for a tick
  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]  id;
    logic [PAY_W-1:0] payload;
    logic [REM_W-1:0] value;
  } req_t;

endpackage
`default_nettype wire

[rtl/ctb_front.sv]
// Front end: accepts requests, drops ignored ones, computes tick deltas.
`default_nettype none
module ctb_front #(
  parameter int NUM_TIMERS = ctb_pkg::NUM_TIMERS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ctb_pkg::CMD_W-1:0]  command,
  input  logic [ctb_pkg::ID_W-1:0]   timer_id,
  input  logic [ctb_pkg::TIME_W-1:0] delay_ms,
  input  logic [ctb_pkg::PAY_W-1:0]  timer_payload,
  input  logic [ctb_pkg::TIME_W-1:0] tick_time_ms,
  input  logic                       q_full,
  output logic                       push,
  output ctb_pkg::req_t              push_req
);
  import ctb_pkg::*;

  logic [TIME_W-1:0] last_uptime;
  logic              accept;
  logic              id_ok;
  logic              keep;

  always_comb begin
    accept           = in_valid && !q_full;
    id_ok            = (timer_id < ID_W'(NUM_TIMERS));
    keep             = 1'b0;
    push_req.op      = OP_SET;
    push_req.id      = timer_id;
    push_req.payload = timer_payload;
    push_req.value   = {1'b0, delay_ms};
    case (command)
      CMD_SET: begin
        keep = id_ok;
      end
      CMD_CANCEL: begin
        keep        = id_ok;
        push_req.op = OP_CANCEL;
      end
      CMD_TICK: begin
        keep           = (tick_time_ms != '0);
        push_req.op    = OP_TICK;
        push_req.value = {1'b0, tick_time_ms} - {1'b0, last_uptime};
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    push     = accept && keep;
    in_stall = q_full;
  end

  // zero uptime clears the reference, which is the same as storing it
  always_ff @(posedge clk) begin
    if (rst) begin
      last_uptime <= '0;
    end else if (accept && (command == CMD_TICK)) begin
      last_uptime <= tick_time_ms;
    end
  end

endmodule
`default_nettype wire

[rtl/ctb_queue.sv]
// Short request queue between front end and timer engine.
`default_nettype none
module ctb_queue #(
  parameter int DEPTH = ctb_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ctb_pkg::req_t push_req,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output ctb_pkg::req_t head
);
  import ctb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  req_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  always_comb begin
    full  = (count == CW'(DEPTH));
    empty = (count == '0);
    head  = entries[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/ctb_back.sv]
// Timer engine: executes set and cancel, sweeps timers on tick, emits expiries.
`default_nettype none
module ctb_back #(
  parameter int NUM_TIMERS = ctb_pkg::NUM_TIMERS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       empty,
  input  ctb_pkg::req_t              head,
  output logic                       pop,
  input  logic [ctb_pkg::NODE_W-1:0] node_position,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ctb_pkg::ID_W-1:0]   expired_id,
  output logic [ctb_pkg::PAY_W-1:0]  expired_payload,
  output logic [ctb_pkg::NODE_W-1:0] event_node,
  output logic                       last_of_run
);
  import ctb_pkg::*;

  localparam int IDXW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNTW = $clog2(NUM_TIMERS + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SWEEP = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [REM_W-1:0] rem_mem [NUM_TIMERS];
  logic [PAY_W-1:0] pay_mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] armed;

  logic [REM_W-1:0] delta;
  logic [CNTW-1:0]  rd_idx;
  logic             p_valid;
  logic [IDXW-1:0]  p_idx;
  logic [REM_W-1:0] rd_rem;
  logic [PAY_W-1:0] rd_pay;
  logic             pend_valid;
  logic [IDXW-1:0]  pend_id;
  logic [PAY_W-1:0] pend_pay;

  logic             rd_done;
  logic             p_armed;
  logic [REM_W:0]   diff;
  logic [REM_W-1:0] new_rem;
  logic             expires;
  logic             out_free;
  logic             p_ok;
  logic             adv;
  logic             rd_en;
  logic             retire;
  logic             set_en;
  logic             cancel_en;
  logic             tick_en;
  logic             wr_en;
  logic [IDXW-1:0]  wr_addr;
  logic [REM_W-1:0] wr_rem;
  logic [IDXW-1:0]  head_idx;
  logic             emit_mid;
  logic             emit_last;

  always_comb begin
    pop       = (state == S_IDLE) && !empty;
    head_idx  = head.id[IDXW-1:0];
    set_en    = pop && (head.op == OP_SET);
    cancel_en = pop && (head.op == OP_CANCEL);
    tick_en   = pop && (head.op == OP_TICK);

    rd_done = (rd_idx == CNTW'(NUM_TIMERS));
    p_armed = armed[p_idx];
    diff    = {rd_rem[REM_W-1], rd_rem} - {delta[REM_W-1], delta};
    if (diff[REM_W] != diff[REM_W-1]) begin
      new_rem = diff[REM_W] ? REM_MIN : REM_MAX;
    end else begin
      new_rem = diff[REM_W-1:0];
    end
    expires  = p_valid && p_armed && (new_rem[REM_W-1] || (new_rem == '0));
    out_free = !out_valid || !out_stall;
    p_ok     = !expires || !pend_valid || out_free;
    adv      = (state == S_SWEEP) && (!p_valid || p_ok);
    rd_en    = adv && !rd_done;
    retire   = (state == S_SWEEP) && p_valid && p_ok;

    wr_en   = set_en || (retire && p_armed);
    wr_addr = set_en ? head_idx : p_idx;
    wr_rem  = set_en ? head.value : new_rem;

    emit_mid  = retire && expires && pend_valid;
    emit_last = (state == S_FLUSH) && pend_valid && out_free;

    state_next = state;
    case (state)
      S_IDLE: begin
        if (tick_en) begin
          state_next = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (adv && rd_done) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rem_mem[wr_addr] <= wr_rem;
    end
    if (set_en) begin
      pay_mem[head_idx] <= head.payload;
    end
    if (rd_en) begin
      rd_rem <= rem_mem[rd_idx[IDXW-1:0]];
      rd_pay <= pay_mem[rd_idx[IDXW-1:0]];
      p_idx  <= rd_idx[IDXW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (tick_en) begin
      delta <= head.value;
    end
    if (retire && expires) begin
      pend_id  <= p_idx;
      pend_pay <= rd_pay;
    end
    if (emit_mid || emit_last) begin
      expired_id      <= ID_W'(pend_id);
      expired_payload <= pend_pay;
      event_node      <= node_position;
      last_of_run     <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      armed      <= '0;
      rd_idx     <= '0;
      p_valid    <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (set_en) begin
        armed[head_idx] <= 1'b1;
      end else if (cancel_en) begin
        armed[head_idx] <= 1'b0;
      end else if (retire && expires) begin
        armed[p_idx] <= 1'b0;
      end
      if (tick_en) begin
        rd_idx  <= '0;
        p_valid <= 1'b0;
      end else if (adv) begin
        if (rd_done) begin
          p_valid <= 1'b0;
        end else begin
          p_valid <= 1'b1;
          rd_idx  <= rd_idx + 1'b1;
        end
      end
      if (retire && expires) begin
        pend_valid <= 1'b1;
      end else if (emit_last) begin
        pend_valid <= 1'b0;
      end
      if (emit_mid || emit_last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/countdown_timer_bank.sv]
// Top level of the countdown timer bank.
`default_nettype none
// Bank of NUM_TIMERS one-shot millisecond timers. The front end takes one
// request per cycle while the queue is not full, into a two-entry queue;
// set and cancel are done as they are popped. A tick occupies the engine
// through the pop, a sweep that reads the timer memory one entry per cycle
// through the read pipeline register, held while an expiry waits on a
// stalled output, and a final flush. Expiries come out in index order;
// the last one of a tick is held back until the sweep ends so it can carry
// last_of_run. node_position is stamped from the configuration register,
// which is always ready and is to be written only while the bank is idle.
module countdown_timer_bank #(
  parameter int NUM_TIMERS = ctb_pkg::NUM_TIMERS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ctb_pkg::CMD_W-1:0]  command,
  input  logic [ctb_pkg::ID_W-1:0]   timer_id,
  input  logic [ctb_pkg::TIME_W-1:0] delay_ms,
  input  logic [ctb_pkg::PAY_W-1:0]  timer_payload,
  input  logic [ctb_pkg::TIME_W-1:0] tick_time_ms,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ctb_pkg::ID_W-1:0]   expired_id,
  output logic [ctb_pkg::PAY_W-1:0]  expired_payload,
  output logic [ctb_pkg::NODE_W-1:0] event_node,
  output logic                       last_of_run,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ctb_pkg::NODE_W-1:0] cfg_data
);
  import ctb_pkg::*;

  logic [NODE_W-1:0] node_position;
  logic              q_full;
  logic              q_empty;
  logic              push;
  logic              pop;
  req_t              push_req;
  req_t              head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_position <= '0;
    end else if (cfg_valid && cfg_ready) begin
      node_position <= cfg_data;
    end
  end

  ctb_front #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .timer_id     (timer_id),
    .delay_ms     (delay_ms),
    .timer_payload(timer_payload),
    .tick_time_ms (tick_time_ms),
    .q_full       (q_full),
    .push         (push),
    .push_req     (push_req)
  );

  ctb_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_req(push_req),
    .full    (q_full),
    .pop     (pop),
    .empty   (q_empty),
    .head    (head)
  );

  ctb_back #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .empty          (q_empty),
    .head           (head),
    .pop            (pop),
    .node_position  (node_position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .expired_id     (expired_id),
    .expired_payload(expired_payload),
    .event_node     (event_node),
    .last_of_run    (last_of_run)
  );

endmodule
`default_nettype wire

[rtl/ctb_checker.sv]
// Port-level checks for the countdown timer bank, bound to the top level.
`default_nettype none
module ctb_checker #(
  parameter int NUM_TIMERS = ctb_pkg::NUM_TIMERS_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [ctb_pkg::ID_W-1:0]   expired_id,
  input logic [ctb_pkg::PAY_W-1:0]  expired_payload,
  input logic                       last_of_run
);
  import ctb_pkg::*;

  logic            in_run;
  logic [ID_W-1:0] prev_id;

  // track the ids of one tick's expiries
  always_ff @(posedge clk) begin
    if (rst) begin
      in_run <= 1'b0;
    end else if (out_valid && !out_stall) begin
      in_run <= !last_of_run;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_stall) begin
      prev_id <= expired_id;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(expired_id) &&
      $stable(expired_payload) && $stable(last_of_run))
    else $error("stalled expiry changed");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> expired_id < ID_W'(NUM_TIMERS))
    else $error("expiry id out of range");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_run |-> expired_id > prev_id)
    else $error("expiries not in ascending order");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("expiry valid after reset");

endmodule

bind countdown_timer_bank ctb_checker #(.NUM_TIMERS(NUM_TIMERS)) u_ctb_checker (.*);
`default_nettype wire

[bench/countdown_timer_bank_checker.sv]
`timescale 1ns / 1ps
// Checker for the countdown timer bank: predicts expiry events and compares them.
module countdown_timer_bank_checker #(
  parameter int NUM_TIMERS = ctb_pkg::NUM_TIMERS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [ctb_pkg::CMD_W-1:0]  command,
  input  logic [ctb_pkg::ID_W-1:0]   timer_id,
  input  logic [ctb_pkg::TIME_W-1:0] delay_ms,
  input  logic [ctb_pkg::PAY_W-1:0]  timer_payload,
  input  logic [ctb_pkg::TIME_W-1:0] tick_time_ms,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [ctb_pkg::ID_W-1:0]   expired_id,
  input  logic [ctb_pkg::PAY_W-1:0]  expired_payload,
  input  logic [ctb_pkg::NODE_W-1:0] event_node,
  input  logic                       last_of_run,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [ctb_pkg::NODE_W-1:0] cfg_data,
  output int                         mismatches,
  output int                         expiries_pending
);
  import ctb_pkg::*;

  typedef struct {
    logic [ID_W-1:0]   id;
    logic [PAY_W-1:0]  payload;
    logic [NODE_W-1:0] node;
    logic              last_of_run;
  } expiry_t;

  logic                    armed_q     [NUM_TIMERS];
  logic signed [REM_W-1:0] remaining_q [NUM_TIMERS];
  logic [PAY_W-1:0]        payload_q   [NUM_TIMERS];
  logic [TIME_W-1:0]       last_uptime_q;
  logic [NODE_W-1:0]       node_q;
  expiry_t                 expected_expiries[$];
  int                      mismatch_total = 0;

  task automatic flag_mismatch(input string msg);
    mismatch_total++;
    if (mismatch_total <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  task automatic check_expiry();
    expiry_t want;
    if (expected_expiries.size() == 0) begin
      flag_mismatch($sformatf("unexpected expiry id=%0d payload=%02h node=%0d last=%0b",
                              expired_id, expired_payload, event_node, last_of_run));
    end else begin
      want = expected_expiries.pop_front();
      if (want.id != expired_id || want.payload != expired_payload ||
          want.node != event_node || want.last_of_run != last_of_run) begin
        flag_mismatch($sformatf({"expiry mismatch: expected id=%0d payload=%02h node=%0d ",
                                 "last=%0b, got id=%0d payload=%02h node=%0d last=%0b"},
                                want.id, want.payload, want.node, want.last_of_run,
                                expired_id, expired_payload, event_node, last_of_run));
      end
    end
  endtask

  task automatic sweep_timers(input logic [TIME_W-1:0] uptime);
    longint  elapsed;
    longint  updated;
    int      fired;
    expiry_t ev;
    elapsed = longint'(uptime) - longint'(last_uptime_q);
    last_uptime_q = uptime;
    fired = 0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (armed_q[i]) begin
        updated = longint'(remaining_q[i]) - elapsed;
        if (updated > 64'sd2147483647) begin
          remaining_q[i] = REM_MAX;
        end else if (updated < -64'sd2147483648) begin
          remaining_q[i] = REM_MIN;
        end else begin
          remaining_q[i] = updated[REM_W-1:0];
        end
        if (remaining_q[i] <= 0) begin
          armed_q[i]     = 1'b0;
          ev.id          = ID_W'(i);
          ev.payload     = payload_q[i];
          ev.node        = node_q;
          ev.last_of_run = 1'b0;
          expected_expiries.push_back(ev);
          fired++;
        end
      end
    end
    if (fired > 0) begin
      expected_expiries[expected_expiries.size() - 1].last_of_run = 1'b1;
    end
  endtask

  task automatic predict_request();
    case (command)
      CMD_SET: begin
        if (timer_id < NUM_TIMERS) begin
          armed_q[timer_id]     = 1'b1;
          remaining_q[timer_id] = {1'b0, delay_ms};
          payload_q[timer_id]   = timer_payload;
        end
      end
      CMD_CANCEL: begin
        if (timer_id < NUM_TIMERS) begin
          armed_q[timer_id] = 1'b0;
        end
      end
      CMD_TICK: begin
        if (tick_time_ms == '0) begin
          last_uptime_q = '0;
        end else begin
          sweep_timers(tick_time_ms);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        armed_q[i]     = 1'b0;
        remaining_q[i] = '0;
        payload_q[i]   = '0;
      end
      last_uptime_q = '0;
      node_q        = '0;
      expected_expiries.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        node_q = cfg_data;
      end
      // results leaving now belong to requests accepted earlier
      if (out_valid && !out_stall) begin
        check_expiry();
      end
      if (in_valid && !in_stall) begin
        predict_request();
      end
    end
    mismatches       <= mismatch_total;
    expiries_pending <= expected_expiries.size();
  end

endmodule

[bench/countdown_timer_bank_tb.sv]
`timescale 1ns / 1ps
// Top of the countdown timer bank testbench: clock, reset, requests and verdict.
module countdown_timer_bank_tb;
  import ctb_pkg::*;

  localparam int                NUM_TIMERS    = NUM_TIMERS_DEF;
  localparam logic [CMD_W-1:0]  CMD_UNUSED    = 2'd3;
  localparam logic [TIME_W-1:0] TIME_MAX      = '1;
  localparam int                SETTLE_CYCLES = 60;
  localparam int                LONG_HOLD     = 400;
  localparam int                PHASE_ITEMS   = 65;
  localparam int                CYCLE_LIMIT   = 1000000;

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              in_valid      = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  command       = '0;
  logic [ID_W-1:0]   timer_id      = '0;
  logic [TIME_W-1:0] delay_ms      = '0;
  logic [PAY_W-1:0]  timer_payload = '0;
  logic [TIME_W-1:0] tick_time_ms  = '0;
  logic              out_valid;
  logic              out_stall     = 1'b0;
  logic [ID_W-1:0]   expired_id;
  logic [PAY_W-1:0]  expired_payload;
  logic [NODE_W-1:0] event_node;
  logic              last_of_run;
  logic              cfg_valid     = 1'b0;
  logic              cfg_ready;
  logic [NODE_W-1:0] cfg_data      = '0;

  int                mismatches;
  int                expiries_pending;
  int                cycles        = 0;
  bit                no_idle       = 1'b0;
  bit                hold_off_req  = 1'b0;
  logic [TIME_W-1:0] now_ms        = '0;

  countdown_timer_bank #(.NUM_TIMERS(NUM_TIMERS)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .timer_id(timer_id), .delay_ms(delay_ms),
    .timer_payload(timer_payload), .tick_time_ms(tick_time_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .expired_id(expired_id), .expired_payload(expired_payload),
    .event_node(event_node), .last_of_run(last_of_run),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  countdown_timer_bank_checker #(.NUM_TIMERS(NUM_TIMERS)) scoreboard (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .timer_id(timer_id), .delay_ms(delay_ms),
    .timer_payload(timer_payload), .tick_time_ms(tick_time_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .expired_id(expired_id), .expired_payload(expired_payload),
    .event_node(event_node), .last_of_run(last_of_run),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .mismatches(mismatches), .expiries_pending(expiries_pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("countdown_timer_bank test failed");
      $finish;
    end
  end

  // mostly short idle runs, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // expiry receiver
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        n = idle_len();
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                              input logic [TIME_W-1:0] delay, input logic [PAY_W-1:0] pay,
                              input logic [TIME_W-1:0] uptime);
    int gap;
    gap = (!no_idle && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    timer_id      <= id;
    delay_ms      <= delay;
    timer_payload <= pay;
    tick_time_ms  <= uptime;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random_request(output bit effective);
    int                r;
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] delay;
    logic [TIME_W-1:0] uptime;
    r = $urandom_range(0, 99);
    if (r < 38) begin
      cmd = CMD_SET;
    end else if (r < 48) begin
      cmd = CMD_CANCEL;
    end else if (r < 95) begin
      cmd = CMD_TICK;
    end else begin
      cmd = CMD_UNUSED;
    end
    id = ($urandom_range(0, 99) < 92) ? ID_W'($urandom_range(0, NUM_TIMERS - 1))
                                      : ID_W'($urandom_range(NUM_TIMERS, 255));
    r = $urandom_range(0, 99);
    if (r < 80) begin
      delay = TIME_W'($urandom_range(0, 150));
    end else if (r < 90) begin
      delay = TIME_W'($urandom_range(0, 5000));
    end else if (r < 97) begin
      delay = TIME_W'($urandom);
    end else begin
      delay = TIME_MAX;
    end
    uptime = TIME_W'($urandom);
    if (cmd == CMD_TICK) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        now_ms = now_ms + TIME_W'($urandom_range(0, 60));
      end else if (r < 87) begin
        now_ms = now_ms + TIME_W'($urandom_range(0, 100000));
      end else if (r < 91) begin
        now_ms = now_ms - TIME_W'($urandom_range(0, 50));
      end else if (r < 95) begin
        now_ms = '0;
      end else begin
        now_ms = TIME_W'($urandom);
      end
      uptime = now_ms;
    end
    effective = (cmd != CMD_UNUSED) && (cmd == CMD_TICK || id < NUM_TIMERS);
    send_request(cmd, id, delay, PAY_W'($urandom), uptime);
  endtask

  // let the bank drain, including requests that raise no expiry
  task automatic settle_bank();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expiries_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_position(input logic [NODE_W-1:0] value);
    settle_bank();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    bit effective;
    int sent;
    int phase;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_node_position(8'hFF);
    send_request(CMD_SET, 8'd0, '0, 8'hA5, '0);
    send_request(CMD_SET, 8'd7, TIME_MAX, 8'hFF, '0);
    send_request(CMD_SET, ID_W'(NUM_TIMERS), 31'd5, 8'h11, '0);
    send_request(CMD_SET, 8'd255, 31'd1, 8'h22, '0);
    send_request(CMD_CANCEL, 8'd255, '0, '0, '0);
    send_request(CMD_TICK, '0, '0, '0, '0);
    send_request(CMD_TICK, '0, '0, '0, 31'd1);
    send_request(CMD_SET, 8'd3, 31'd10, 8'h3C, '0);
    send_request(CMD_SET, 8'd4, 31'd10, 8'hC3, '0);
    send_request(CMD_SET, 8'd5, 31'd20, 8'h55, '0);
    send_request(CMD_CANCEL, 8'd4, '0, '0, '0);
    send_request(CMD_UNUSED, 8'd2, 31'd1, 8'h66, 31'd100);
    send_request(CMD_TICK, '0, '0, '0, 31'd11);
    // uptime going backwards, then a jump to the top of the range
    send_request(CMD_TICK, '0, '0, '0, 31'd5);
    send_request(CMD_TICK, '0, '0, '0, TIME_MAX);
    // a large negative step pins the remaining time at the signed maximum
    send_request(CMD_SET, 8'd7, TIME_MAX, 8'h77, '0);
    send_request(CMD_TICK, '0, '0, '0, 31'd1);
    send_request(CMD_TICK, '0, '0, '0, '0);
    send_request(CMD_TICK, '0, '0, '0, TIME_MAX);
    for (int i = 0; i < NUM_TIMERS; i++) begin
      send_request(CMD_SET, ID_W'(i), '0, PAY_W'(i * 8'h24) ^ 8'h81, '0);
    end
    send_request(CMD_TICK, '0, '0, '0, '0);
    send_request(CMD_TICK, '0, '0, '0, 31'd7);
    now_ms = 31'd7;

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       write_node_position(8'h00);
        3:       write_node_position(8'hFF);
        default: write_node_position(NODE_W'($urandom));
      endcase
      sent = 0;
      if (phase == 1) begin
        // expiry side holds off while the bank keeps being fed
        hold_off_req = 1'b1;
        repeat (3) begin
          for (int i = 0; i < NUM_TIMERS; i++) begin
            send_request(CMD_SET, ID_W'(i), 31'($urandom_range(0, 20)), PAY_W'($urandom),
                         31'($urandom));
          end
          now_ms = now_ms + TIME_W'(30);
          send_request(CMD_TICK, ID_W'($urandom), 31'($urandom), PAY_W'($urandom), now_ms);
          sent += NUM_TIMERS + 1;
        end
      end
      while (sent < PHASE_ITEMS) begin
        no_idle = (phase == 2 && sent < PHASE_ITEMS / 2);
        send_random_request(effective);
        if (effective) begin
          sent++;
        end
      end
      no_idle = 1'b0;
    end

    settle_bank();
    if (mismatches == 0 && expiries_pending == 0) begin
      $display("countdown_timer_bank test passed");
    end else begin
      $display("countdown_timer_bank test failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ctb_pkg.sv
rtl/ctb_front.sv
rtl/ctb_queue.sv
rtl/ctb_back.sv
rtl/countdown_timer_bank.sv
rtl/ctb_checker.sv
bench/countdown_timer_bank_checker.sv
bench/countdown_timer_bank_tb.sv
